@@ sv/dsa_pkg.sv @@
// descriptor slot allocator package: request modes, status codes, fsm states
// and the command/status structs between controller and datapath
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dsa_pkg;

  localparam int GRP_W  = 16;
  localparam int GRP_IW = 4;

  typedef enum logic [1:0] {
    MODE_ALLOC_LOW = 2'd0,
    MODE_ALLOC_AT  = 2'd1,
    MODE_FREE      = 2'd2,
    MODE_READ      = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SLOT = 2'd1,
    ST_IN_USE   = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ sv/dsa_req_if.sv @@
// request channel: valid/ready handshake with mode, slot and handle
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface dsa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  slot;
  logic [31:0] handle;

  modport source (output valid, output mode, output slot, output handle, input ready);
  modport sink (input valid, input mode, input slot, input handle, output ready);
endinterface

`default_nettype wire

@@ sv/dsa_rsp_if.sv @@
// response channel: valid/ready handshake with status, slot and handle
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface dsa_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  slot_out;
  logic [31:0] handle_out;

  modport source (output valid, output status, output slot_out, output handle_out,
                  input ready);
  modport sink (input valid, input status, input slot_out, input handle_out,
                output ready);
endinterface

`default_nettype wire

@@ sv/dsa_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module dsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output      logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/dsa_ctrl.sv @@
// controller fsm: takes one request, then commits it once the output register is free
// depends on dsa_pkg
`timescale 1ns / 1ps
`default_nettype none

module dsa_ctrl
  import dsa_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output      logic       req_ready,
  input  wire dp_stat_t   stat,
  output      ctrl_cmd_t  cmd,
  output      state_t     state
);

  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready   = !rst;
        cmd.capture = req_valid && !rst;
      end
      S_EXEC: begin
        cmd.commit = stat.out_free;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/dsa_datapath.sv @@
// datapath: occupancy bitmap, handle table ram, free-slot group summaries,
// request registers and the output register
// depends on dsa_pkg and dsa_ram
`timescale 1ns / 1ps
`default_nettype none

module dsa_datapath
  import dsa_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ctrl_cmd_t   cmd,
  output      dp_stat_t    stat,
  input  wire logic [1:0]  in_mode,
  input  wire logic [7:0]  in_slot,
  input  wire logic [31:0] in_handle,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [1:0]  out_status,
  output      logic [7:0]  out_slot,
  output      logic [31:0] out_handle
);

  localparam int IW  = $clog2(SLOTS);
  localparam int NG  = (SLOTS + GRP_W - 1) / GRP_W;
  localparam int GSW = (NG > 1) ? $clog2(NG) : 1;
  localparam int FW  = GSW + GRP_IW;
  localparam logic [8:0] SlotsW = 9'(SLOTS);

  logic [SLOTS-1:0]    occ;
  logic [NG*GRP_W-1:0] occ_pad;

  mode_t       mode_q;
  logic [7:0]  slot_q;
  logic [31:0] handle_q;
  logic        in_range_q;

  logic [NG-1:0]     grp_free;
  logic [GRP_IW-1:0] grp_low [NG];
  logic [NG-1:0]     grp_free_q;
  logic [GRP_IW-1:0] grp_low_q [NG];

  logic [IW-1:0] raddr;
  logic [31:0]   rdata;

  logic          any_free;
  logic [GSW-1:0] gsel;
  logic [FW-1:0] found;
  logic          slot_occ;

  status_t       res_status;
  logic [7:0]    res_slot;
  logic [31:0]   res_handle;
  logic          set_en;
  logic          clr_en;
  logic [IW-1:0] widx;

  assign stat.out_free = !out_valid || out_ready;

  // free-slot summary per group of the bitmap, registered at capture
  always_comb begin
    occ_pad = '1;
    occ_pad[SLOTS-1:0] = occ;
    for (int g = 0; g < NG; g++) begin
      grp_free[g] = 1'b0;
      grp_low[g]  = '0;
      for (int b = GRP_W - 1; b >= 0; b--) begin
        if (!occ_pad[g*GRP_W + b]) begin
          grp_free[g] = 1'b1;
          grp_low[g]  = GRP_IW'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q     <= mode_t'(in_mode);
      slot_q     <= in_slot;
      handle_q   <= in_handle;
      in_range_q <= {1'b0, in_slot} < SlotsW;
      grp_free_q <= grp_free;
      for (int g = 0; g < NG; g++) begin
        grp_low_q[g] <= grp_low[g];
      end
    end
  end

  assign raddr = cmd.capture ? in_slot[IW-1:0] : slot_q[IW-1:0];

  dsa_ram #(
    .WIDTH(32),
    .DEPTH(SLOTS)
  ) u_table (
    .clk  (clk),
    .we   (cmd.commit && set_en),
    .waddr(widx),
    .wdata(handle_q),
    .raddr(raddr),
    .rdata(rdata)
  );

  // lowest group with a free slot
  always_comb begin
    any_free = |grp_free_q;
    gsel     = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_free_q[g]) gsel = GSW'(g);
    end
    found = {gsel, grp_low_q[gsel]};
  end

  always_comb begin
    res_status = ST_OK;
    res_slot   = '0;
    res_handle = '0;
    set_en     = 1'b0;
    clr_en     = 1'b0;
    widx       = slot_q[IW-1:0];
    slot_occ   = 1'b0;
    if (in_range_q) slot_occ = occ[slot_q[IW-1:0]];
    unique case (mode_q)
      MODE_ALLOC_LOW: begin
        widx = found[IW-1:0];
        if (any_free) begin
          res_slot = 8'(found);
          set_en   = handle_q != '0;
        end else begin
          res_status = ST_FULL;
        end
      end
      MODE_ALLOC_AT: begin
        if (!in_range_q) begin
          res_status = ST_BAD_SLOT;
        end else if (slot_occ) begin
          res_status = ST_IN_USE;
        end else begin
          res_slot = slot_q;
          set_en   = handle_q != '0;
        end
      end
      MODE_FREE: begin
        if (!in_range_q || !slot_occ) begin
          res_status = ST_BAD_SLOT;
        end else begin
          res_slot = slot_q;
          clr_en   = 1'b1;
        end
      end
      MODE_READ: begin
        if (!in_range_q || !slot_occ) begin
          res_status = ST_BAD_SLOT;
        end else begin
          res_slot   = slot_q;
          res_handle = rdata;
        end
      end
      default: res_status = ST_BAD_SLOT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (cmd.commit) begin
      if (set_en) occ[widx] <= 1'b1;
      if (clr_en) occ[widx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status <= res_status;
      out_slot   <= res_slot;
      out_handle <= res_handle;
    end
  end

endmodule

`default_nettype wire

@@ sv/descriptor_slot_allocator.sv @@
// descriptor slot allocator top level: controller, datapath and channel hookup
// depends on dsa_pkg, dsa_req_if, dsa_rsp_if, dsa_ctrl, dsa_datapath
//
//   channel  dir  payload                            transaction
//   req      in   mode[1:0] slot[7:0] handle[31:0]   valid && ready
//   rsp      out  status[1:0] slot_out[7:0]          valid && ready
//                 handle_out[31:0]
//
// one request at a time, in order: capture (table ram read, free-group summaries
// registered) then commit (result to output register, bitmap and ram write)
// commit uses the registered read data of the table ram's synchronous read port
// reset empties the table at once through the occupancy bitmap, no sweep
// a new request is taken while a result waits; its commit waits for rsp ready
`timescale 1ns / 1ps
`default_nettype none

module descriptor_slot_allocator
  import dsa_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input wire logic  clk,
  input wire logic  rst,
  dsa_req_if.sink   req,
  dsa_rsp_if.source rsp
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  state_t    state;

  dsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req.valid),
    .req_ready(req.ready),
    .stat     (stat),
    .cmd      (cmd),
    .state    (state)
  );

  dsa_datapath #(
    .SLOTS(SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_mode   (req.mode),
    .in_slot   (req.slot),
    .in_handle (req.handle),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_status(rsp.status),
    .out_slot  (rsp.slot_out),
    .out_handle(rsp.handle_out)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while another is in flight");

  a_fail_zeroes: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_OK |-> rsp.slot_out == '0 && rsp.handle_out == '0)
    else $error("failed response carries slot or handle");

  a_rsp_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(cmd.commit) && $past(state == S_EXEC))
    else $error("response raised without a commit");

endmodule

`default_nettype wire
